>>> rtl/sbsh_pkg.sv
// Shared types, command codes and constants for the SHA-256 byte stream hasher.
// Depends on nothing; the top level, sequencer, datapath and testbench import it.
`timescale 1ns / 1ps
`default_nettype none

package sbsh_pkg;

   localparam int unsigned WORD_W  = 32;
   localparam int unsigned BLOCK_W = 512;
   localparam int unsigned ROUNDS  = 64;

   localparam logic [1:0] SEL_INPUT = 2'd0;
   localparam logic [1:0] SEL_PAD   = 2'd1;
   localparam logic [1:0] SEL_ZERO  = 2'd2;
   localparam logic [1:0] SEL_LEN   = 2'd3;

   localparam logic [5:0] FILL_LAST = 6'd63;
   localparam logic [5:0] FILL_LEN  = 6'd56;
   localparam logic [7:0] PAD_BYTE  = 8'h80;

   localparam logic [31:0] HASH_INIT [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   typedef struct packed {
      logic [7:0] message_byte;
      logic       byte_present;
      logic       end_of_message;
   } req_payload_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_payload_type;

   typedef struct packed {
      logic       shift_en;
      logic [1:0] byte_sel;
      logic       count_en;
      logic       load_work;
      logic       round_en;
      logic       add_hash;
      logic       clear;
      logic [2:0] out_idx;
   } cmd_type;

   typedef struct packed {
      logic [5:0] fill;
      logic       round_last;
   } sts_type;

endpackage

`default_nettype wire

>>> rtl/sbsh_stream_if.sv
// Valid/ready stream channel carrying one payload word per handshake.
// Depends on nothing; the payload type is set where the channel is instantiated.
`timescale 1ns / 1ps
`default_nettype none

interface sbsh_stream_if #(parameter type payload_type = logic);

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);

endinterface

`default_nettype wire

>>> rtl/sha256_byte_stream_hash.sv
// Top level of the SHA-256 byte stream hasher: joins the sequencer and the datapath.
// Depends on sbsh_pkg, sbsh_stream_if, sbsh_ctrl and sbsh_datapath.
//
//   Channel    Direction  Word per handshake
//   req_chan   in         message_byte, byte_present, end_of_message
//   rsp_chan   out        digest_word, word_index, last_word
//
// Message bytes are taken while the sequencer is idle. Each full 64-byte block then holds
// the input while the working words are loaded, 64 rounds of the shared round logic run and
// the result is added into the chaining words. A final word adds the padding bytes and one or
// two compressions, then offers eight digest words, one per cycle while rsp_chan is ready.
// Reset is synchronous and restores the initial chaining words.
`timescale 1ns / 1ps
`default_nettype none

module sha256_byte_stream_hash
   import sbsh_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   sbsh_stream_if.sink    req_chan,
   sbsh_stream_if.source  rsp_chan
);

   cmd_type     cmd;
   sts_type     sts;
   logic [31:0] digest_word;
   logic        rsp_valid;
   logic        req_ready;
   logic [2:0]  word_index;
   logic        last_word;

   sbsh_ctrl u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_chan.valid),
      .req_byte_present   (req_chan.payload.byte_present),
      .req_end_of_message (req_chan.payload.end_of_message),
      .req_ready          (req_ready),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_chan.ready),
      .rsp_word_index     (word_index),
      .rsp_last_word      (last_word),
      .cmd                (cmd),
      .sts                (sts)
   );

   sbsh_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .message_byte (req_chan.payload.message_byte),
      .cmd          (cmd),
      .sts          (sts),
      .digest_word  (digest_word)
   );

   assign req_chan.ready = req_ready;
   assign rsp_chan.valid = rsp_valid;
   assign rsp_chan.payload.digest_word = digest_word;
   assign rsp_chan.payload.word_index = word_index;
   assign rsp_chan.payload.last_word = last_word;

endmodule

`default_nettype wire

>>> rtl/sbsh_ctrl.sv
// Sequencer of the SHA-256 byte stream hasher: byte intake, padding, rounds, digest output.
// Depends on sbsh_pkg for command and status types.
`timescale 1ns / 1ps
`default_nettype none

module sbsh_ctrl
   import sbsh_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   input  wire logic    req_byte_present,
   input  wire logic    req_end_of_message,
   output logic         req_ready,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output logic [2:0]   rsp_word_index,
   output logic         rsp_last_word,
   output cmd_type      cmd,
   input  wire sts_type sts
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_PAD   = 3'd1;
   localparam logic [2:0] ST_ZERO  = 3'd2;
   localparam logic [2:0] ST_LEN   = 3'd3;
   localparam logic [2:0] ST_LOAD  = 3'd4;
   localparam logic [2:0] ST_ROUND = 3'd5;
   localparam logic [2:0] ST_ADD   = 3'd6;
   localparam logic [2:0] ST_OUT   = 3'd7;

   logic [2:0] state_ff, state_in;
   logic [2:0] ret_ff, ret_in;
   logic [2:0] idx_ff, idx_in;
   logic       full;

   assign full = (sts.fill == FILL_LAST);

   always_comb begin
      cmd = '0;
      cmd.out_idx = idx_ff;
      state_in = state_ff;
      ret_in = ret_ff;
      idx_in = idx_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = !reset;
            if (req_valid) begin
               if (req_byte_present) begin
                  cmd.shift_en = 1'b1;
                  cmd.byte_sel = SEL_INPUT;
                  cmd.count_en = 1'b1;
                  if (full) begin
                     state_in = ST_LOAD;
                     ret_in = req_end_of_message ? ST_PAD : ST_IDLE;
                  end else if (req_end_of_message) begin
                     state_in = ST_PAD;
                  end
               end else if (req_end_of_message) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            cmd.shift_en = 1'b1;
            cmd.byte_sel = SEL_PAD;
            if (full) begin
               state_in = ST_LOAD;
               ret_in = ST_ZERO;
            end else begin
               state_in = ST_ZERO;
            end
         end
         ST_ZERO: begin
            if (sts.fill == FILL_LEN) begin
               state_in = ST_LEN;
            end else begin
               cmd.shift_en = 1'b1;
               cmd.byte_sel = SEL_ZERO;
               if (full) begin
                  state_in = ST_LOAD;
                  ret_in = ST_ZERO;
               end
            end
         end
         ST_LEN: begin
            cmd.shift_en = 1'b1;
            cmd.byte_sel = SEL_LEN;
            if (full) begin
               state_in = ST_LOAD;
               ret_in = ST_OUT;
            end
         end
         ST_LOAD: begin
            cmd.load_work = 1'b1;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            cmd.round_en = 1'b1;
            if (sts.round_last) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            cmd.add_hash = 1'b1;
            idx_in = '0;
            state_in = ret_ff;
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (idx_ff == 3'd7) begin
                  cmd.clear = 1'b1;
                  idx_in = '0;
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff + 3'd1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_word_index = idx_ff;
   assign rsp_last_word = (idx_ff == 3'd7);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ret_ff <= ST_IDLE;
         idx_ff <= '0;
      end else begin
         state_ff <= state_in;
         ret_ff <= ret_in;
         idx_ff <= idx_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/sbsh_datapath.sv
// Datapath of the SHA-256 byte stream hasher: block shift line, round logic, chaining words.
// Depends on sbsh_pkg for constants, command and status types.
`timescale 1ns / 1ps
`default_nettype none

module sbsh_datapath
   import sbsh_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic [7:0] message_byte,
   input  wire cmd_type    cmd,
   output sts_type         sts,
   output logic [31:0]     digest_word
);

   function automatic logic [31:0] big_sigma0(input logic [31:0] x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic logic [31:0] big_sigma1(input logic [31:0] x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic logic [31:0] small_sigma0(input logic [31:0] x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
   endfunction

   function automatic logic [31:0] small_sigma1(input logic [31:0] x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
   endfunction

   logic [BLOCK_W-1:0] blk_ff;
   logic [31:0]        work_ff [8];
   logic [31:0]        hash_ff [8];
   logic [5:0]         fill_ff;
   logic [5:0]         rnd_ff;
   logic [63:0]        bits_ff;

   logic [7:0]  byte_in;
   logic [31:0] w0, w1, w9, w14, w_new;
   logic [31:0] t1, t2, ch, maj;

   // The oldest word of the block sits at the top of the shift line.
   assign w0  = blk_ff[BLOCK_W-1      -: WORD_W];
   assign w1  = blk_ff[BLOCK_W-1-32   -: WORD_W];
   assign w9  = blk_ff[BLOCK_W-1-288  -: WORD_W];
   assign w14 = blk_ff[BLOCK_W-1-448  -: WORD_W];
   assign w_new = small_sigma1(w14) + w9 + small_sigma0(w1) + w0;

   always_comb begin
      case (cmd.byte_sel)
         SEL_INPUT: byte_in = message_byte;
         SEL_PAD:   byte_in = PAD_BYTE;
         SEL_ZERO:  byte_in = 8'h00;
         SEL_LEN:   byte_in = bits_ff[63:56];
         default:   byte_in = 8'h00;
      endcase
   end

   assign ch  = (work_ff[4] & work_ff[5]) ^ (~work_ff[4] & work_ff[6]);
   assign maj = (work_ff[0] & work_ff[1]) ^ (work_ff[0] & work_ff[2])
              ^ (work_ff[1] & work_ff[2]);
   assign t1  = work_ff[7] + big_sigma1(work_ff[4]) + ch + ROUND_K[rnd_ff] + w0;
   assign t2  = big_sigma0(work_ff[0]) + maj;

   always_ff @(posedge clock) begin
      if (cmd.shift_en) begin
         blk_ff <= {blk_ff[BLOCK_W-9:0], byte_in};
      end else if (cmd.round_en) begin
         blk_ff <= {blk_ff[BLOCK_W-WORD_W-1:0], w_new};
      end
      if (cmd.load_work) begin
         work_ff <= hash_ff;
      end else if (cmd.round_en) begin
         work_ff[0] <= t1 + t2;
         work_ff[1] <= work_ff[0];
         work_ff[2] <= work_ff[1];
         work_ff[3] <= work_ff[2];
         work_ff[4] <= work_ff[3] + t1;
         work_ff[5] <= work_ff[4];
         work_ff[6] <= work_ff[5];
         work_ff[7] <= work_ff[6];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         fill_ff <= '0;
         rnd_ff <= '0;
         bits_ff <= '0;
         hash_ff <= HASH_INIT;
      end else begin
         if (cmd.shift_en) begin
            fill_ff <= fill_ff + 6'd1;
         end
         if (cmd.count_en) begin
            bits_ff <= bits_ff + 64'd8;
         end else if (cmd.shift_en && cmd.byte_sel == SEL_LEN) begin
            bits_ff <= {bits_ff[55:0], 8'h00};
         end
         if (cmd.load_work) begin
            rnd_ff <= '0;
         end else if (cmd.round_en) begin
            rnd_ff <= rnd_ff + 6'd1;
         end
         if (cmd.add_hash) begin
            for (int i = 0; i < 8; i++) begin
               hash_ff[i] <= hash_ff[i] + work_ff[i];
            end
         end
      end
   end

   assign sts.fill = fill_ff;
   assign sts.round_last = (rnd_ff == 6'(ROUNDS - 1));
   assign digest_word = hash_ff[cmd.out_idx];

endmodule

`default_nettype wire

>>> tb/tb_sha256_byte_stream_hash.sv
// Self-checking testbench for the SHA-256 byte stream hasher: messages of random length
// and content go in one byte per word, and every digest word is checked against a predictor.
// Depends on sbsh_pkg, sbsh_stream_if and sha256_byte_stream_hash.
`timescale 1ns / 1ps

module tb_sha256_byte_stream_hash
   import sbsh_pkg::*;
();

   localparam logic [31:0] SHA_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [31:0] SHA_IV [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam int BOUNDARY_LENS [12] = '{0, 1, 55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
   localparam int RANDOM_ITEMS = 270;
   localparam int HOLD_CYCLES  = 600;
   localparam int DRAIN_CYCLES = 300;

   typedef struct {
      req_payload_type word;
      bit              drain_first;
   } pending_item_type;

   logic clock;
   logic reset;

   sbsh_stream_if #(.payload_type(req_payload_type)) req_chan ();
   sbsh_stream_if #(.payload_type(rsp_payload_type)) rsp_chan ();

   sha256_byte_stream_hash uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   logic [31:0] chain_words [8];
   logic [7:0]  block_bytes [64];
   int          block_fill;
   logic [63:0] message_bits;

   pending_item_type byte_stream_q [$];
   rsp_payload_type  digest_expected [$];
   pending_item_type launch_item;

   int mismatch_count;
   int queued_words;
   int digest_words_seen;
   int burst_left;
   int gap_left;
   int hold_left;
   bit hold_done;
   int ready_mode;
   int mode_left;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic logic [31:0] rotr(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   task automatic sha_restart();
      chain_words = SHA_IV;
      for (int i = 0; i < 64; i++) block_bytes[i] = 8'h00;
      block_fill = 0;
      message_bits = 64'd0;
   endtask

   task automatic sha_compress();
      logic [31:0] w [64];
      logic [31:0] v [8];
      logic [31:0] s0, s1, t1, t2;
      for (int r = 0; r < 16; r++) begin
         w[r] = {block_bytes[4*r], block_bytes[4*r+1], block_bytes[4*r+2], block_bytes[4*r+3]};
      end
      for (int r = 16; r < 64; r++) begin
         s0 = rotr(w[r-15], 7) ^ rotr(w[r-15], 18) ^ (w[r-15] >> 3);
         s1 = rotr(w[r-2], 17) ^ rotr(w[r-2], 19) ^ (w[r-2] >> 10);
         w[r] = s1 + w[r-7] + s0 + w[r-16];
      end
      v = chain_words;
      for (int r = 0; r < 64; r++) begin
         t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[r] + w[r];
         t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6];
         v[6] = v[5];
         v[5] = v[4];
         v[4] = v[3] + t1;
         v[3] = v[2];
         v[2] = v[1];
         v[1] = v[0];
         v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) chain_words[i] = chain_words[i] + v[i];
   endtask

   task automatic sha_absorb(req_payload_type word);
      logic [63:0]     total;
      rsp_payload_type dw;
      if (word.byte_present) begin
         block_bytes[block_fill] = word.message_byte;
         block_fill++;
         if (block_fill == 64) begin
            sha_compress();
            message_bits = message_bits + 64'd512;
            block_fill = 0;
         end
      end
      if (word.end_of_message) begin
         total = message_bits + 64'(block_fill) * 64'd8;
         block_bytes[block_fill] = 8'h80;
         for (int i = block_fill + 1; i < 64; i++) block_bytes[i] = 8'h00;
         if (block_fill >= 56) begin
            sha_compress();
            for (int i = 0; i < 64; i++) block_bytes[i] = 8'h00;
         end
         for (int i = 0; i < 8; i++) block_bytes[56+i] = total[63-8*i -: 8];
         sha_compress();
         for (int i = 0; i < 8; i++) begin
            dw.digest_word = chain_words[i];
            dw.word_index = 3'(i);
            dw.last_word = (i == 7);
            digest_expected.push_back(dw);
         end
         sha_restart();
      end
   endtask

   task automatic queue_word(logic [7:0] b, bit present, bit last, bit drain);
      pending_item_type it;
      it.word.message_byte = b;
      it.word.byte_present = present;
      it.word.end_of_message = last;
      it.drain_first = drain;
      byte_stream_q.push_back(it);
      if (present || last) queued_words++;
   endtask

   task automatic queue_message(int len, bit close_with_byte, int noise_pct, bit drain);
      bit first;
      first = drain;
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(99) < noise_pct) begin
            queue_word(8'($urandom), 1'b0, 1'b0, first);
            first = 1'b0;
         end
         queue_word(8'($urandom), 1'b1, close_with_byte && (i == len - 1), first);
         first = 1'b0;
      end
      if (!close_with_byte || len == 0) queue_word(8'($urandom), 1'b0, 1'b1, first);
   endtask

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH at %0t: %s got %h expected %h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_chan.ready) begin
         if (req_chan.valid) sha_absorb(req_chan.payload);
         if (gap_left > 0) begin
            gap_left--;
            req_chan.valid <= 1'b0;
         end else if (byte_stream_q.size() > 0 &&
                      (!byte_stream_q[0].drain_first || digest_expected.size() == 0)) begin
            launch_item = byte_stream_q.pop_front();
            req_chan.valid <= 1'b1;
            req_chan.payload <= launch_item.word;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 40);
               gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
            end
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (!hold_done && digest_words_seen >= 16) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            digest_words_seen++;
            if (digest_expected.size() == 0) begin
               report("unexpected digest word", rsp_chan.payload.digest_word, 32'd0);
            end else begin
               if (rsp_chan.payload.digest_word !== digest_expected[0].digest_word)
                  report("digest_word", rsp_chan.payload.digest_word,
                         digest_expected[0].digest_word);
               if (rsp_chan.payload.word_index !== digest_expected[0].word_index)
                  report("word_index", 32'(rsp_chan.payload.word_index),
                         32'(digest_expected[0].word_index));
               if (rsp_chan.payload.last_word !== digest_expected[0].last_word)
                  report("last_word", 32'(rsp_chan.payload.last_word),
                         32'(digest_expected[0].last_word));
               void'(digest_expected.pop_front());
            end
         end
         if (mode_left == 0) begin
            mode_left = $urandom_range(10, 60);
            ready_mode = $urandom_range(3);
         end else begin
            mode_left--;
         end
         if (hold_left > 0) begin
            rsp_chan.ready <= 1'b0;
         end else begin
            case (ready_mode)
               0: rsp_chan.ready <= 1'b1;
               1: rsp_chan.ready <= 1'($urandom);
               2: rsp_chan.ready <= ($urandom_range(3) == 0);
               default: rsp_chan.ready <= ~rsp_chan.ready;
            endcase
         end
      end
   end

   initial begin
      #2_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      int len;
      int rand_msgs;
      bit drained_mid;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.payload = '0;
      rsp_chan.ready = 1'b0;
      mismatch_count = 0;
      queued_words = 0;
      digest_words_seen = 0;
      burst_left = 0;
      gap_left = 0;
      ready_mode = 0;
      mode_left = 0;
      sha_restart();

      // Directed: empty message, "abc" closed on its last byte, absent bytes mixed in,
      // all-zero and all-one bytes, and empty messages between other messages.
      queue_word(8'h00, 1'b0, 1'b1, 1'b0);
      queue_word(8'h61, 1'b1, 1'b0, 1'b0);
      queue_word(8'h62, 1'b1, 1'b0, 1'b0);
      queue_word(8'h63, 1'b1, 1'b1, 1'b0);
      queue_word(8'hff, 1'b0, 1'b0, 1'b0);
      queue_word(8'h00, 1'b1, 1'b0, 1'b0);
      queue_word(8'h5a, 1'b0, 1'b0, 1'b0);
      queue_word(8'hff, 1'b1, 1'b0, 1'b0);
      queue_word(8'hff, 1'b0, 1'b1, 1'b0);
      queue_word(8'hff, 1'b0, 1'b1, 1'b0);
      queue_word(8'hff, 1'b1, 1'b1, 1'b0);
      for (int i = 0; i < 8; i++) queue_word((i % 2) ? 8'haa : 8'h55, 1'b1, i == 7, 1'b0);
      queue_word(8'h00, 1'b0, 1'b1, 1'b0);

      rand_msgs = 0;
      drained_mid = 1'b0;
      queued_words = 0;
      while (queued_words < RANDOM_ITEMS || rand_msgs < 6) begin
         if ($urandom_range(9) < 3) len = BOUNDARY_LENS[$urandom_range(11)];
         else len = $urandom_range(0, 40);
         queue_message(len, 1'($urandom), 5,
                       rand_msgs == 0 || (!drained_mid && queued_words > RANDOM_ITEMS / 2));
         if (queued_words > RANDOM_ITEMS / 2) drained_mid = 1'b1;
         rand_msgs++;
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (byte_stream_q.size() > 0 || req_chan.valid) @(posedge clock);
      while (digest_expected.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
